// ----- rtl/ngh_pkg.sv -----
`timescale 1ns / 1ps

package ngh_pkg;

  localparam int DEF_MAX_CHANNELS = 8;
  localparam int DEF_SAMPLE_BITS  = 24;
  localparam int DEF_COEFF_BITS   = 24;

  localparam int NUM_CH_PORTS   = 8;
  localparam int CH_IDX_BITS    = $clog2(NUM_CH_PORTS);
  localparam int CNT_BITS       = 4;
  localparam int LEVEL_BITS     = 24;
  localparam int COEFF_REG_BITS = 24;
  localparam int CFG_DATA_BITS  = 24;
  localparam int CFG_IDX_BITS   = 3;
  localparam int QUEUE_DEPTH    = 2;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_ENABLE,
    REG_CHANNEL_COUNT,
    REG_OPEN_LEVEL,
    REG_CLOSE_LEVEL,
    REG_ATTACK_COEFF,
    REG_RELEASE_COEFF
  } cfg_reg_t;

  typedef struct packed {
    logic                      enable;
    logic [CNT_BITS-1:0]       channel_count;
    logic [LEVEL_BITS-1:0]     open_level;
    logic [LEVEL_BITS-1:0]     close_level;
    logic [COEFF_REG_BITS-1:0] attack_coeff;
    logic [COEFF_REG_BITS-1:0] release_coeff;
  } cfg_t;

  localparam logic                      RST_ENABLE        = 1'b1;
  localparam logic [CNT_BITS-1:0]       RST_CHANNEL_COUNT = 4'd2;
  localparam logic [LEVEL_BITS-1:0]     RST_OPEN_LEVEL    = 24'd262144;
  localparam logic [LEVEL_BITS-1:0]     RST_CLOSE_LEVEL   = 24'd131072;
  localparam logic [COEFF_REG_BITS-1:0] RST_ATTACK_COEFF  = 24'd0;
  localparam logic [COEFF_REG_BITS-1:0] RST_RELEASE_COEFF = 24'd0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ENV_ACC,
    ST_ENV_SUM,
    ST_GATE,
    ST_GAIN_MUL,
    ST_GAIN_SUM,
    ST_SCALE,
    ST_DONE
  } back_state_t;

endpackage

// ----- rtl/noise_gate_hysteresis_core.sv -----
// A request at the queue head passes through the back end states ENV_ACC, ENV_SUM, GATE,
//   GAIN_MUL, GAIN_SUM, SCALE (over the active channels) and DONE; when disabled or with
//   no active channels it goes straight from IDLE to DONE. The back end sequencer shares one
//   multiplier for envelope, gain and per-channel scaling and works on one request at a time;
//   a 2-entry queue sits between front and back, so new requests are accepted while the back
//   end is busy until the queue is full, and the output register holds one finished result.
// Reset (rst_n low, synchronous): registers to defaults, envelope 0, gain unity, gate closed.
`timescale 1ns / 1ps

module noise_gate_hysteresis_core #(
  parameter int MAX_CHANNELS = ngh_pkg::DEF_MAX_CHANNELS,
  parameter int SAMPLE_BITS  = ngh_pkg::DEF_SAMPLE_BITS,
  parameter int COEFF_BITS   = ngh_pkg::DEF_COEFF_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [ngh_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [ngh_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [SAMPLE_BITS-1:0]        in_sample_0,
  input  logic signed [SAMPLE_BITS-1:0]        in_sample_1,
  input  logic signed [SAMPLE_BITS-1:0]        in_sample_2,
  input  logic signed [SAMPLE_BITS-1:0]        in_sample_3,
  input  logic signed [SAMPLE_BITS-1:0]        in_sample_4,
  input  logic signed [SAMPLE_BITS-1:0]        in_sample_5,
  input  logic signed [SAMPLE_BITS-1:0]        in_sample_6,
  input  logic signed [SAMPLE_BITS-1:0]        in_sample_7,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [SAMPLE_BITS-1:0]        out_0,
  output logic signed [SAMPLE_BITS-1:0]        out_1,
  output logic signed [SAMPLE_BITS-1:0]        out_2,
  output logic signed [SAMPLE_BITS-1:0]        out_3,
  output logic signed [SAMPLE_BITS-1:0]        out_4,
  output logic signed [SAMPLE_BITS-1:0]        out_5,
  output logic signed [SAMPLE_BITS-1:0]        out_6,
  output logic signed [SAMPLE_BITS-1:0]        out_7,
  output logic                                 out_gate_is_open,
  output logic [COEFF_BITS:0]                  out_applied_gain
);
  import ngh_pkg::*;

  localparam int EW = NUM_CH_PORTS * SAMPLE_BITS + SAMPLE_BITS + CNT_BITS + 1;

  cfg_t cfg_r, cfg_nxt;

  logic [NUM_CH_PORTS-1:0][SAMPLE_BITS-1:0] in_smp;
  logic [NUM_CH_PORTS-1:0][SAMPLE_BITS-1:0] h_samples;
  logic [NUM_CH_PORTS-1:0][SAMPLE_BITS-1:0] res_smp;
  logic [SAMPLE_BITS-1:0] f_level, h_level;
  logic [CNT_BITS-1:0]    f_n, h_n;
  logic                   f_bypass, h_bypass;
  logic                   push, q_full, q_nonempty, q_pop;
  logic [EW-1:0]          push_data, head_data;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_ENABLE:        cfg_nxt.enable        = cfg_data[0];
        REG_CHANNEL_COUNT: cfg_nxt.channel_count = cfg_data[CNT_BITS-1:0];
        REG_OPEN_LEVEL:    cfg_nxt.open_level    = LEVEL_BITS'(cfg_data);
        REG_CLOSE_LEVEL:   cfg_nxt.close_level   = LEVEL_BITS'(cfg_data);
        REG_ATTACK_COEFF:  cfg_nxt.attack_coeff  = COEFF_REG_BITS'(cfg_data);
        REG_RELEASE_COEFF: cfg_nxt.release_coeff = COEFF_REG_BITS'(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable        <= RST_ENABLE;
      cfg_r.channel_count <= RST_CHANNEL_COUNT;
      cfg_r.open_level    <= RST_OPEN_LEVEL;
      cfg_r.close_level   <= RST_CLOSE_LEVEL;
      cfg_r.attack_coeff  <= RST_ATTACK_COEFF;
      cfg_r.release_coeff <= RST_RELEASE_COEFF;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_smp[0] = in_sample_0;
  assign in_smp[1] = in_sample_1;
  assign in_smp[2] = in_sample_2;
  assign in_smp[3] = in_sample_3;
  assign in_smp[4] = in_sample_4;
  assign in_smp[5] = in_sample_5;
  assign in_smp[6] = in_sample_6;
  assign in_smp[7] = in_sample_7;

  assign in_stall = q_full;

  ngh_front #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_front (
    .in_valid (in_valid),
    .q_full   (q_full),
    .cfg      (cfg_r),
    .samples  (in_smp),
    .push     (push),
    .level    (f_level),
    .n_act    (f_n),
    .bypass   (f_bypass)
  );

  assign push_data = {in_smp, f_level, f_n, f_bypass};

  ngh_fifo #(
    .WIDTH (EW)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .nonempty  (q_nonempty),
    .head_data (head_data)
  );

  assign {h_samples, h_level, h_n, h_bypass} = head_data;

  ngh_back #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEFF_BITS  (COEFF_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_nonempty (q_nonempty),
    .h_samples  (h_samples),
    .h_level    (h_level),
    .h_n        (h_n),
    .h_bypass   (h_bypass),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_smp    (res_smp),
    .out_open   (out_gate_is_open),
    .out_gain   (out_applied_gain)
  );

  assign out_0 = $signed(res_smp[0]);
  assign out_1 = $signed(res_smp[1]);
  assign out_2 = $signed(res_smp[2]);
  assign out_3 = $signed(res_smp[3]);
  assign out_4 = $signed(res_smp[4]);
  assign out_5 = $signed(res_smp[5]);
  assign out_6 = $signed(res_smp[6]);
  assign out_7 = $signed(res_smp[7]);

endmodule

// ----- rtl/ngh_front.sv -----
`timescale 1ns / 1ps

module ngh_front #(
  parameter int MAX_CHANNELS = ngh_pkg::DEF_MAX_CHANNELS,
  parameter int SAMPLE_BITS  = ngh_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                                 in_valid,
  input  logic                                                 q_full,
  input  ngh_pkg::cfg_t                                        cfg,
  input  logic [ngh_pkg::NUM_CH_PORTS-1:0][SAMPLE_BITS-1:0]    samples,
  output logic                                                 push,
  output logic [SAMPLE_BITS-1:0]                               level,
  output logic [ngh_pkg::CNT_BITS-1:0]                         n_act,
  output logic                                                 bypass
);
  import ngh_pkg::*;

  // active count, bypass decision, peak magnitude over active channels and queue push
  always_comb begin
    logic [SAMPLE_BITS-1:0] mag;
    n_act = (cfg.channel_count > CNT_BITS'(MAX_CHANNELS)) ? CNT_BITS'(MAX_CHANNELS)
                                                         : cfg.channel_count;
    bypass = !cfg.enable || (n_act == '0);
    level  = '0;
    for (int k = 0; k < NUM_CH_PORTS; k++) begin
      mag = samples[k][SAMPLE_BITS-1] ? (~samples[k] + 1'b1) : samples[k];
      if ((CNT_BITS'(k) < n_act) && (mag > level)) begin
        level = mag;
      end
    end
    push = in_valid && !q_full;
  end

endmodule

// ----- rtl/ngh_fifo.sv -----
`timescale 1ns / 1ps

module ngh_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             nonempty,
  output logic [WIDTH-1:0] head_data
);
  import ngh_pkg::*;

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0]    mem_r [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;

  assign full      = (count_r == CNT_W'(QUEUE_DEPTH));
  assign nonempty  = (count_r != '0);
  assign head_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- rtl/ngh_back.sv -----
`timescale 1ns / 1ps

module ngh_back #(
  parameter int SAMPLE_BITS = ngh_pkg::DEF_SAMPLE_BITS,
  parameter int COEFF_BITS  = ngh_pkg::DEF_COEFF_BITS
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  ngh_pkg::cfg_t                                     cfg,
  input  logic                                              q_nonempty,
  input  logic [ngh_pkg::NUM_CH_PORTS-1:0][SAMPLE_BITS-1:0] h_samples,
  input  logic [SAMPLE_BITS-1:0]                            h_level,
  input  logic [ngh_pkg::CNT_BITS-1:0]                      h_n,
  input  logic                                              h_bypass,
  output logic                                              q_pop,
  output logic                                              out_valid,
  input  logic                                              out_stall,
  output logic [ngh_pkg::NUM_CH_PORTS-1:0][SAMPLE_BITS-1:0] out_smp,
  output logic                                              out_open,
  output logic [COEFF_BITS:0]                               out_gain
);
  import ngh_pkg::*;

  localparam int S  = SAMPLE_BITS;
  localparam int C  = COEFF_BITS;
  localparam int M  = (S > C + 1) ? S : C + 1;
  localparam int PW = C + 1 + M;
  localparam int AW = PW + 1;
  localparam int CW = (S > LEVEL_BITS) ? S : LEVEL_BITS;

  localparam logic [C:0]    UNITY  = {1'b1, {C{1'b0}}};
  localparam logic [AW-1:0] HALF_W = {{(AW - C){1'b0}}, 1'b1, {(C - 1){1'b0}}};
  localparam logic [S:0]    SMAX_W = {2'b00, {(S - 1){1'b1}}};
  localparam logic [S:0]    LIMN_W = {2'b01, {(S - 1){1'b0}}};

  back_state_t state_r, state_nxt;

  logic [S-1:0]           env_r, env_nxt;
  logic [C:0]             gain_r, gain_nxt;
  logic                   open_r, open_nxt;
  logic [C-1:0]           coef_r, coef_nxt;
  logic [AW-1:0]          acc_r, acc_nxt;
  logic [PW-1:0]          prod_r;
  logic [CNT_BITS-1:0]    ch_r, ch_nxt;
  logic [CH_IDX_BITS-1:0] prev_r, prev_nxt;
  logic [NUM_CH_PORTS-1:0][S-1:0] res_r, res_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [NUM_CH_PORTS-1:0][S-1:0] out_smp_r, out_smp_nxt;
  logic                   out_open_r, out_open_nxt;
  logic [C:0]             out_gain_r, out_gain_nxt;

  logic [C:0]   mul_a;
  logic [M-1:0] mul_b;
  logic [C-1:0] atk_c, rel_c;

  assign atk_c     = C'(cfg.attack_coeff);
  assign rel_c     = C'(cfg.release_coeff);
  assign out_valid = out_valid_r;
  assign out_smp   = out_smp_r;
  assign out_open  = out_open_r;
  assign out_gain  = out_gain_r;

  always_comb begin
    logic [C-1:0]  csel;
    logic [AW-1:0] sum;
    logic [AW-1:0] tgt;
    logic [S-1:0]  smp;
    logic [S-1:0]  mag;
    logic          neg;
    logic [S:0]    rmag;
    logic [S:0]    rneg;

    state_nxt     = state_r;
    env_nxt       = env_r;
    gain_nxt      = gain_r;
    open_nxt      = open_r;
    coef_nxt      = coef_r;
    acc_nxt       = acc_r;
    ch_nxt        = ch_r;
    prev_nxt      = prev_r;
    res_nxt       = res_r;
    out_smp_nxt   = out_smp_r;
    out_open_nxt  = out_open_r;
    out_gain_nxt  = out_gain_r;
    out_valid_nxt = out_valid_r && out_stall;
    q_pop         = 1'b0;
    mul_a         = '0;
    mul_b         = '0;

    csel = '0;
    sum  = '0;
    tgt  = '0;
    smp  = '0;
    mag  = '0;
    neg  = 1'b0;
    rmag = '0;
    rneg = '0;

    case (state_r)
      ST_IDLE: begin
        if (q_nonempty) begin
          if (h_bypass) begin
            for (int k = 0; k < NUM_CH_PORTS; k++) begin
              res_nxt[k] = (CNT_BITS'(k) < h_n) ? h_samples[k] : '0;
            end
            state_nxt = ST_DONE;
          end else begin
            res_nxt   = '0;
            csel      = (h_level > env_r) ? atk_c : rel_c;
            coef_nxt  = csel;
            mul_a     = {1'b0, csel};
            mul_b     = M'(env_r);
            state_nxt = ST_ENV_ACC;
          end
        end
      end
      ST_ENV_ACC: begin
        acc_nxt   = AW'(prod_r);
        mul_a     = UNITY - {1'b0, coef_r};
        mul_b     = M'(h_level);
        state_nxt = ST_ENV_SUM;
      end
      ST_ENV_SUM: begin
        sum       = acc_r + AW'(prod_r) + HALF_W;
        env_nxt   = S'(sum >> C);
        state_nxt = ST_GATE;
      end
      ST_GATE: begin
        if (open_r) begin
          if (CW'(env_r) <= CW'(cfg.close_level)) begin
            open_nxt = 1'b0;
          end
        end else if (CW'(env_r) >= CW'(cfg.open_level)) begin
          open_nxt = 1'b1;
        end
        state_nxt = ST_GAIN_MUL;
      end
      ST_GAIN_MUL: begin
        csel      = open_r ? atk_c : rel_c;
        coef_nxt  = csel;
        mul_a     = {1'b0, csel};
        mul_b     = M'(gain_r);
        state_nxt = ST_GAIN_SUM;
      end
      ST_GAIN_SUM: begin
        if (open_r) begin
          tgt = AW'(UNITY - {1'b0, coef_r}) << C;
        end
        sum = AW'(prod_r) + tgt + HALF_W;
        sum = sum >> C;
        gain_nxt  = (sum > AW'(UNITY)) ? UNITY : (C + 1)'(sum);
        ch_nxt    = '0;
        state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        // issue channel ch_r, finish channel ch_r - 1 from the product register
        smp   = h_samples[ch_r[CH_IDX_BITS-1:0]];
        mag   = smp[S-1] ? (~smp + 1'b1) : smp;
        mul_a = gain_r;
        mul_b = M'(mag);
        if (ch_r != '0) begin
          neg  = h_samples[prev_r][S-1];
          sum  = AW'(prod_r) + (neg ? (HALF_W - AW'(1)) : HALF_W);
          rmag = (S + 1)'(sum >> C);
          if (!neg) begin
            res_nxt[prev_r] = (rmag > SMAX_W) ? SMAX_W[S-1:0] : rmag[S-1:0];
          end else begin
            rneg = '0 - rmag;
            res_nxt[prev_r] = (rmag > LIMN_W) ? LIMN_W[S-1:0] : rneg[S-1:0];
          end
        end
        prev_nxt = ch_r[CH_IDX_BITS-1:0];
        ch_nxt   = ch_r + 1'b1;
        if (ch_r == h_n) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_smp_nxt   = res_r;
          out_open_nxt  = open_r;
          out_gain_nxt  = h_bypass ? UNITY : gain_r;
          out_valid_nxt = 1'b1;
          q_pop         = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      env_r       <= '0;
      gain_r      <= UNITY;
      open_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      env_r       <= env_nxt;
      gain_r      <= gain_nxt;
      open_r      <= open_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    coef_r     <= coef_nxt;
    acc_r      <= acc_nxt;
    prod_r     <= mul_a * mul_b;
    ch_r       <= ch_nxt;
    prev_r     <= prev_nxt;
    res_r      <= res_nxt;
    out_smp_r  <= out_smp_nxt;
    out_open_r <= out_open_nxt;
    out_gain_r <= out_gain_nxt;
  end

endmodule
